### design/dczh_pkg.sv
// Shared constants, widths and codes of the depth change zone histogram.
`default_nettype none

package dczh_pkg;

    // Default geometry, handed to the top level as parameter defaults.
    localparam int FRAME_WIDTH_DEF    = 640;
    localparam int FRAME_HEIGHT_DEF   = 480;
    localparam int ZONES_PER_AXIS_DEF = 3;
    localparam int RAW_LIMIT_DEF      = 1000;

    // Field widths of the input and result items.
    localparam int ACTION_W = 2;
    localparam int RAW_W    = 11;
    localparam int COL_W    = 10;
    localparam int ROW_W    = 9;
    localparam int BIN_W    = 3;
    localparam int SHARE_W  = 17;
    localparam int CNT_W    = 19;
    localparam int FRAC_W   = 16;
    localparam int BG_W     = 10;
    localparam int MM_W     = 13;

    // Stream bus widths.
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 56;
    localparam int M_USER_W = 2 * BIN_W;

    // Configuration register widths and reset values.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 19;
    localparam int CBW_W      = 10;
    localparam int DBW_W      = 12;
    localparam int THR_W      = 12;
    localparam logic [CBW_W-1:0] CBW_RST = 10'd210;
    localparam logic [DBW_W-1:0] DBW_RST = 12'd1283;
    localparam logic [THR_W-1:0] THR_RST = 12'd200;
    localparam logic [CNT_W-1:0] MINP_RST = 19'd2000;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Shared divider geometry: a 45-bit dividend, a 36-bit divisor, 17 quotient bits.
    localparam int DIV_DVD_W = 45;
    localparam int DIV_DVS_W = 36;
    localparam int DIV_Q_W   = 17;

    // Raw to millimetre conversion: mm = (2*10^13 + den) / (2*den),
    // with den = 33309495161 - 30711016 * raw.
    localparam int DEN_W = 35;
    localparam logic [DEN_W-1:0]     MM_DEN_BASE  = 35'd33309495161;
    localparam logic [DEN_W-1:0]     MM_DEN_SLOPE = 35'd30711016;
    localparam logic [DIV_DVD_W-1:0] MM_NUM       = 45'd20000000000000;

    // Pixel actions.
    typedef enum logic [ACTION_W-1:0] {
        ACT_CALIBRATE = 2'd0,
        ACT_DETECT    = 2'd1,
        ACT_FORGET    = 2'd2,
        ACT_NOP       = 2'd3
    } action_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COL_BIN_W   = 2'd0,
        REG_DEPTH_BIN_W = 2'd1,
        REG_THRESHOLD   = 2'd2,
        REG_MIN_POINTS  = 2'd3
    } cfg_reg_t;

endpackage

`default_nettype wire

### design/dczh_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module dczh_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### design/dczh_div.sv
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none

module dczh_div
    import dczh_pkg::*;
#(
    parameter int DVD_W = DIV_DVD_W,
    parameter int DVS_W = DIV_DVS_W,
    parameter int Q_W   = DIV_Q_W
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  done,
    output logic      [Q_W-1:0]   quotient
);

    localparam int SH_W  = DVS_W + Q_W - 1;
    localparam int CNT_W_L = $clog2(Q_W);

    logic               run_reg,  run_next;
    logic               done_reg, done_next;
    logic [CNT_W_L-1:0] step_reg, step_next;
    logic [DVD_W-1:0]   rem_reg,  rem_next;
    logic [SH_W-1:0]    dsh_reg,  dsh_next;
    logic [Q_W-1:0]     q_reg,    q_next;
    logic [SH_W-1:0]    rem_wide;
    logic               fits;

    assign rem_wide = SH_W'(rem_reg);
    assign fits     = (rem_wide >= dsh_reg);

    // One compare and subtract per cycle against the shifted divisor.
    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        if (start)
        begin
            run_next  = 1'b1;
            step_next = CNT_W_L'(Q_W - 1);
            rem_next  = dividend;
            dsh_next  = SH_W'(divisor) << (Q_W - 1);
            q_next    = '0;
        end
        else if (run_reg)
        begin
            if (fits)
            begin
                rem_next = DVD_W'(rem_wide - dsh_reg);
            end
            q_next   = {q_reg[Q_W-2:0], fits};
            dsh_next = dsh_reg >> 1;
            if (step_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

### design/depth_change_zone_histogram.sv
// Top level: pixel sequencer, background store, zone counters and share output.
// One item at a time, as the input is ready only while idle: calibrate, forget, no-op, gated-out
// and out-of-frame pixels skip the divider; a detect runs two distance divisions on the shared
// divider, and a counted detect adds a column and a depth division; a zero bin width skips it.
// An end-of-frame item with shares emits one share per zone and waits while the output stalls.
// Reset clears the calibration flag, counters, frame total and config; not the background.
`default_nettype none

module depth_change_zone_histogram
    import dczh_pkg::*;
#(
    parameter int FRAME_WIDTH    = FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT   = FRAME_HEIGHT_DEF,
    parameter int ZONES_PER_AXIS = ZONES_PER_AXIS_DEF,
    parameter int RAW_LIMIT      = RAW_LIMIT_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Configuration write channel.
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // Pixel input stream.
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [S_DATA_W-1:0]   s_axis_tdata,  // raw_depth, column, row, zero pad
    input  wire logic [ACTION_W-1:0]   s_axis_tuser,  // action
    input  wire logic                  s_axis_tlast,  // end_of_frame
    // Share output stream.
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic      [M_DATA_W-1:0]   m_axis_tdata,  // share, zone_count, total_count, pad
    output logic      [M_USER_W-1:0]   m_axis_tuser,  // column_bin, depth_bin
    output logic                       m_axis_tlast   // last
);

    localparam int PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int PAW    = $clog2(PIXELS);
    localparam int ZONES  = ZONES_PER_AXIS * ZONES_PER_AXIS;
    localparam int ZAW    = (ZONES > 1) ? $clog2(ZONES) : 1;
    localparam int LIN_W  = 21;
    localparam logic [BIN_W-1:0] LAST_BIN  = BIN_W'(ZONES_PER_AXIS - 1);
    localparam logic [ZAW-1:0]   LAST_ZONE = ZAW'(ZONES - 1);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CUR_DEN,
        ST_CUR_DIV,
        ST_CUR_WAIT,
        ST_BG_DEN,
        ST_BG_DIV,
        ST_BG_WAIT,
        ST_CMP,
        ST_COL_DIV,
        ST_COL_WAIT,
        ST_DEP_DIV,
        ST_DEP_WAIT,
        ST_ZONE_RD,
        ST_ZONE_WR,
        ST_FINISH,
        ST_EMIT_RD,
        ST_SH_DIV,
        ST_SH_WAIT,
        ST_OUT_LOAD
    } state_t;

    // Configuration registers.
    logic [CBW_W-1:0] cbw_reg;
    logic [DBW_W-1:0] dbw_reg;
    logic [THR_W-1:0] thr_reg;
    logic [CNT_W-1:0] minp_reg;

    // Sequencer state and item registers.
    state_t               state_reg,    state_next;
    logic [ACTION_W-1:0]  act_reg,      act_next;
    logic [RAW_W-1:0]     raw_reg,      raw_next;
    logic [COL_W-1:0]     col_reg,      col_next;
    logic [ROW_W-1:0]     row_reg,      row_next;
    logic                 eof_reg,      eof_next;
    logic                 bg_valid_reg, bg_valid_next;
    logic [DEN_W-1:0]     den_reg,      den_next;
    logic [MM_W-1:0]      cur_mm_reg,   cur_mm_next;
    logic [MM_W-1:0]      bg_mm_reg,    bg_mm_next;
    logic [BIN_W-1:0]     cb_reg,       cb_next;
    logic [BIN_W-1:0]     db_reg,       db_next;
    logic [ZAW-1:0]       zidx_reg,     zidx_next;
    logic [CNT_W-1:0]     total_reg,    total_next;
    logic [ZONES-1:0]     zvalid_reg,   zvalid_next;
    logic [CNT_W-1:0]     cnt_reg,      cnt_next;

    // Output registers.
    logic                 m_valid_reg,   m_valid_next;
    logic [BIN_W-1:0]     out_cb_reg,    out_cb_next;
    logic [BIN_W-1:0]     out_db_reg,    out_db_next;
    logic [SHARE_W-1:0]   out_share_reg, out_share_next;
    logic [CNT_W-1:0]     out_cnt_reg,   out_cnt_next;
    logic [CNT_W-1:0]     out_total_reg, out_total_next;
    logic                 out_last_reg,  out_last_next;

    // Datapath and memory signals.
    logic                 s_accept;
    logic                 in_frame;
    logic [LIN_W-1:0]     pix_lin;
    logic [PAW-1:0]       pix_addr;
    logic                 pix_wr_en;
    logic [BG_W-1:0]      pix_wr_data;
    logic                 pix_rd_en;
    logic [BG_W-1:0]      pix_rd_data;
    logic [BG_W-1:0]      den_raw;
    logic [DEN_W-1:0]     den_calc;
    logic [MM_W-1:0]      mm_diff;
    logic                 hit;
    logic [5:0]           zone_lin;
    logic [ZAW-1:0]       zone_calc;
    logic                 zone_wr_en;
    logic [CNT_W-1:0]     zone_wr_data;
    logic                 zone_rd_en;
    logic [ZAW-1:0]       zone_rd_addr;
    logic [CNT_W-1:0]     zone_rd_data;
    logic [CNT_W-1:0]     zone_cur;
    logic                 div_start;
    logic [DIV_DVD_W-1:0] div_dvd;
    logic [DIV_DVS_W-1:0] div_dvs;
    logic                 div_done;
    logic [DIV_Q_W-1:0]   div_q;
    logic [BIN_W-1:0]     q_bin;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cbw_reg  <= CBW_RST;
            dbw_reg  <= DBW_RST;
            thr_reg  <= THR_RST;
            minp_reg <= MINP_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_COL_BIN_W:   cbw_reg  <= cfg_data[CBW_W-1:0];
                REG_DEPTH_BIN_W: dbw_reg  <= cfg_data[DBW_W-1:0];
                REG_THRESHOLD:   thr_reg  <= cfg_data[THR_W-1:0];
                REG_MIN_POINTS:  minp_reg <= cfg_data[CNT_W-1:0];
                default:         cbw_reg  <= cbw_reg;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // Pixel position checks and linear address.
    assign in_frame = (11'(col_reg) < 11'(FRAME_WIDTH))
                   && (11'(row_reg) < 11'(FRAME_HEIGHT));
    assign pix_lin  = LIN_W'(row_reg) * LIN_W'(FRAME_WIDTH) + LIN_W'(col_reg);
    assign pix_addr = pix_lin[PAW-1:0];

    assign pix_wr_en   = (state_reg == ST_EXEC) && (act_reg == ACT_CALIBRATE) && in_frame;
    assign pix_wr_data = (raw_reg < RAW_W'(RAW_LIMIT)) ? raw_reg[BG_W-1:0] : BG_W'(RAW_LIMIT);
    assign pix_rd_en   = (state_reg == ST_EXEC);

    dczh_ram #(
        .WIDTH  (BG_W),
        .DEPTH  (PIXELS),
        .ADDR_W (PAW)
    ) u_bg_ram (
        .clk     (clk),
        .wr_en   (pix_wr_en),
        .wr_addr (pix_addr),
        .wr_data (pix_wr_data),
        .rd_en   (pix_rd_en),
        .rd_addr (pix_addr),
        .rd_data (pix_rd_data)
    );

    // Conversion denominator for the current or the background reading.
    assign den_raw  = (state_reg == ST_BG_DEN) ? pix_rd_data : raw_reg[BG_W-1:0];
    assign den_calc = MM_DEN_BASE - MM_DEN_SLOPE * DEN_W'(den_raw);

    // Distance change against the threshold.
    assign mm_diff = (cur_mm_reg > bg_mm_reg) ? (cur_mm_reg - bg_mm_reg)
                                              : (bg_mm_reg - cur_mm_reg);
    assign hit     = (mm_diff > MM_W'(thr_reg));

    // Zone index and counter memory.
    assign zone_lin  = 6'(cb_reg) * 6'(ZONES_PER_AXIS) + 6'(db_reg);
    assign zone_calc = zone_lin[ZAW-1:0];

    assign zone_rd_en   = (state_reg == ST_ZONE_RD) || (state_reg == ST_EMIT_RD);
    assign zone_rd_addr = (state_reg == ST_ZONE_RD) ? zone_calc : zidx_reg;
    assign zone_cur     = zvalid_reg[zidx_reg] ? zone_rd_data : '0;
    assign zone_wr_en   = (state_reg == ST_ZONE_WR);
    assign zone_wr_data = (zone_cur == CNT_MAX) ? zone_cur : zone_cur + 1'b1;

    dczh_ram #(
        .WIDTH  (CNT_W),
        .DEPTH  (ZONES),
        .ADDR_W (ZAW)
    ) u_zone_ram (
        .clk     (clk),
        .wr_en   (zone_wr_en),
        .wr_addr (zidx_reg),
        .wr_data (zone_wr_data),
        .rd_en   (zone_rd_en),
        .rd_addr (zone_rd_addr),
        .rd_data (zone_rd_data)
    );

    // Shared divider operand selection.
    always_comb
    begin
        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = '0;
        case (state_reg)
            ST_CUR_DIV, ST_BG_DIV:
            begin
                div_start = 1'b1;
                div_dvd   = MM_NUM + DIV_DVD_W'(den_reg);
                div_dvs   = {den_reg, 1'b0};
            end
            ST_COL_DIV:
            begin
                div_start = 1'b1;
                div_dvd   = DIV_DVD_W'(col_reg);
                div_dvs   = DIV_DVS_W'(cbw_reg);
            end
            ST_DEP_DIV:
            begin
                div_start = (dbw_reg != '0);
                div_dvd   = DIV_DVD_W'(cur_mm_reg);
                div_dvs   = DIV_DVS_W'(dbw_reg);
            end
            ST_SH_DIV:
            begin
                div_start = 1'b1;
                div_dvd   = DIV_DVD_W'({zone_cur, {FRAC_W{1'b0}}});
                div_dvs   = DIV_DVS_W'(total_reg);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    dczh_div #(
        .DVD_W (DIV_DVD_W),
        .DVS_W (DIV_DVS_W),
        .Q_W   (DIV_Q_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    // Bin index clamped to the last bin.
    assign q_bin = (div_q >= DIV_Q_W'(ZONES_PER_AXIS)) ? LAST_BIN : div_q[BIN_W-1:0];

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        raw_next       = raw_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        eof_next       = eof_reg;
        bg_valid_next  = bg_valid_reg;
        den_next       = den_reg;
        cur_mm_next    = cur_mm_reg;
        bg_mm_next     = bg_mm_reg;
        cb_next        = cb_reg;
        db_next        = db_reg;
        zidx_next      = zidx_reg;
        total_next     = total_reg;
        zvalid_next    = zvalid_reg;
        cnt_next       = cnt_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        out_cb_next    = out_cb_reg;
        out_db_next    = out_db_reg;
        out_share_next = out_share_reg;
        out_cnt_next   = out_cnt_reg;
        out_total_next = out_total_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    act_next   = s_axis_tuser;
                    raw_next   = s_axis_tdata[RAW_W-1:0];
                    col_next   = s_axis_tdata[RAW_W+COL_W-1:RAW_W];
                    row_next   = s_axis_tdata[RAW_W+COL_W+ROW_W-1:RAW_W+COL_W];
                    eof_next   = s_axis_tlast;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_FINISH;
                case (act_reg)
                    ACT_CALIBRATE:
                    begin
                        bg_valid_next = 1'b1;
                    end
                    ACT_DETECT:
                    begin
                        if (in_frame && (raw_reg < RAW_W'(RAW_LIMIT)) && bg_valid_reg)
                        begin
                            state_next = ST_CUR_DEN;
                        end
                    end
                    ACT_FORGET:
                    begin
                        bg_valid_next = 1'b0;
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_CUR_DEN:
            begin
                den_next   = den_calc;
                state_next = ST_CUR_DIV;
            end
            ST_CUR_DIV:
            begin
                state_next = ST_CUR_WAIT;
            end
            ST_CUR_WAIT:
            begin
                if (div_done)
                begin
                    cur_mm_next = div_q[MM_W-1:0];
                    state_next  = ST_BG_DEN;
                end
            end
            ST_BG_DEN:
            begin
                den_next   = den_calc;
                state_next = ST_BG_DIV;
            end
            ST_BG_DIV:
            begin
                state_next = ST_BG_WAIT;
            end
            ST_BG_WAIT:
            begin
                if (div_done)
                begin
                    bg_mm_next = div_q[MM_W-1:0];
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (!hit)
                begin
                    state_next = ST_FINISH;
                end
                else if (cbw_reg == '0)
                begin
                    cb_next    = LAST_BIN;
                    state_next = ST_DEP_DIV;
                end
                else
                begin
                    state_next = ST_COL_DIV;
                end
            end
            ST_COL_DIV:
            begin
                state_next = ST_COL_WAIT;
            end
            ST_COL_WAIT:
            begin
                if (div_done)
                begin
                    cb_next    = q_bin;
                    state_next = ST_DEP_DIV;
                end
            end
            ST_DEP_DIV:
            begin
                if (dbw_reg == '0)
                begin
                    db_next    = LAST_BIN;
                    state_next = ST_ZONE_RD;
                end
                else
                begin
                    state_next = ST_DEP_WAIT;
                end
            end
            ST_DEP_WAIT:
            begin
                if (div_done)
                begin
                    db_next    = q_bin;
                    state_next = ST_ZONE_RD;
                end
            end
            ST_ZONE_RD:
            begin
                zidx_next  = zone_calc;
                state_next = ST_ZONE_WR;
            end
            ST_ZONE_WR:
            begin
                zvalid_next[zidx_reg] = 1'b1;
                if (total_reg != CNT_MAX)
                begin
                    total_next = total_reg + 1'b1;
                end
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
                if (eof_reg)
                begin
                    if (bg_valid_reg && (total_reg > minp_reg))
                    begin
                        zidx_next  = '0;
                        cb_next    = '0;
                        db_next    = '0;
                        state_next = ST_EMIT_RD;
                    end
                    else
                    begin
                        zvalid_next = '0;
                        total_next  = '0;
                    end
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_SH_DIV;
            end
            ST_SH_DIV:
            begin
                cnt_next   = zone_cur;
                state_next = ST_SH_WAIT;
            end
            ST_SH_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT_LOAD;
                end
            end
            ST_OUT_LOAD:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next   = 1'b1;
                    out_cb_next    = cb_reg;
                    out_db_next    = db_reg;
                    out_share_next = div_q;
                    out_cnt_next   = cnt_reg;
                    out_total_next = total_reg;
                    out_last_next  = (zidx_reg == LAST_ZONE);
                    if (zidx_reg == LAST_ZONE)
                    begin
                        zvalid_next = '0;
                        total_next  = '0;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        zidx_next = zidx_reg + 1'b1;
                        if (db_reg == LAST_BIN)
                        begin
                            db_next = '0;
                            cb_next = cb_reg + 1'b1;
                        end
                        else
                        begin
                            db_next = db_reg + 1'b1;
                        end
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, control and output registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            bg_valid_reg <= 1'b0;
            total_reg    <= '0;
            zvalid_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            bg_valid_reg <= bg_valid_next;
            total_reg    <= total_next;
            zvalid_reg   <= zvalid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        raw_reg       <= raw_next;
        col_reg       <= col_next;
        row_reg       <= row_next;
        eof_reg       <= eof_next;
        den_reg       <= den_next;
        cur_mm_reg    <= cur_mm_next;
        bg_mm_reg     <= bg_mm_next;
        cb_reg        <= cb_next;
        db_reg        <= db_next;
        zidx_reg      <= zidx_next;
        cnt_reg       <= cnt_next;
        out_cb_reg    <= out_cb_next;
        out_db_reg    <= out_db_next;
        out_share_reg <= out_share_next;
        out_cnt_reg   <= out_cnt_next;
        out_total_reg <= out_total_next;
        out_last_reg  <= out_last_next;
    end

    // Result bus packing.
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, out_total_reg, out_cnt_reg, out_share_reg};
    assign m_axis_tuser  = {out_db_reg, out_cb_reg};
    assign m_axis_tlast  = out_last_reg;

    // A divider result only arrives while the sequencer waits for it.
    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_CUR_WAIT || state_reg == ST_BG_WAIT ||
                      state_reg == ST_COL_WAIT || state_reg == ST_DEP_WAIT ||
                      state_reg == ST_SH_WAIT))
        else $error("divider finished outside a wait state");

    // A share never exceeds one in Q1.16.
    a_share_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> (out_share_reg <= SHARE_W'(32'h10000)))
        else $error("share out of range");

    // A zone count never exceeds the frame total it is shown with.
    a_zone_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> (out_cnt_reg <= out_total_reg))
        else $error("zone count above frame total");

    // Counting a body pixel leaves a nonzero frame total.
    a_total_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ZONE_WR) |=> (total_reg != '0))
        else $error("frame total not advanced");

endmodule

`default_nettype wire
